// File: hdl/facet_printability_classifier_core_assert.svh
// Assertion macros for the facet printability classifier core.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef FACET_PRINTABILITY_CLASSIFIER_CORE_ASSERT_SVH
`define FACET_PRINTABILITY_CLASSIFIER_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define FPC_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("same-cycle check failed");
// Next-cycle implication.
`define FPC_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("next-cycle check failed");
`else
`define FPC_ASSERT_NOW(name, clk, rst, pre, post)
`define FPC_ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

// File: hdl/fpc_pkg.sv
// Shared types, field layout and constants for the facet printability classifier.
// No dependencies; imported by every module of the block.
`default_nettype none

package fpc_pkg;

   // Field widths
   localparam int THICK_W        = 20;
   localparam int AREA_W         = 22;
   localparam int NORMAL_W       = 16;
   localparam int HEIGHT_W       = 21;
   localparam int FLAGS_W        = 4;
   localparam int DEG_W          = 8;
   localparam int CAT_IDX_W      = 2;
   localparam int CAT_FACETS_W   = 24;
   localparam int CAT_AREA_W     = 48;
   localparam int LEAN_W         = 7;
   localparam int NUM_FLAGS      = 4;
   localparam int NUM_LEAN_STEPS = 90;

   // Request tdata layout
   localparam int REQ_THICK_LSB  = 0;
   localparam int REQ_AREA_LSB   = REQ_THICK_LSB + THICK_W;
   localparam int REQ_NORMAL_LSB = REQ_AREA_LSB + AREA_W;
   localparam int REQ_TOP_LSB    = REQ_NORMAL_LSB + NORMAL_W;
   localparam int REQ_DATA_W     = 80;

   // Response tdata layout
   localparam int RSP_FLAGS_LSB      = 0;
   localparam int RSP_DEG_LSB        = RSP_FLAGS_LSB + FLAGS_W;
   localparam int RSP_CAT_IDX_LSB    = RSP_DEG_LSB + DEG_W;
   localparam int RSP_CAT_FACETS_LSB = RSP_CAT_IDX_LSB + CAT_IDX_W;
   localparam int RSP_CAT_AREA_LSB   = RSP_CAT_FACETS_LSB + CAT_FACETS_W;
   localparam int RSP_CAT_LEAN_LSB   = RSP_CAT_AREA_LSB + CAT_AREA_W;
   localparam int RSP_MESH_AREA_LSB  = RSP_CAT_LEAN_LSB + LEAN_W;
   localparam int RSP_DATA_W         = 144;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [1:0] {
      CSR_THIN_CRITICAL = 2'd0,
      CSR_THIN_WARNING  = 2'd1,
      CSR_BED_BAND_TOP  = 2'd2
   } csr_index_type;

   // Flag bit positions
   localparam int FLAG_THIN_CRITICAL = 0;
   localparam int FLAG_THIN_WARNING  = 1;
   localparam int FLAG_EXTERNAL      = 2;
   localparam int FLAG_INTERNAL      = 3;

   localparam logic KIND_FACET    = 1'b0;
   localparam logic KIND_CATEGORY = 1'b1;

   localparam logic [DEG_W-1:0]     NOT_OVERHANG = 8'd255;
   localparam logic [CAT_IDX_W-1:0] CAT_FIRST    = 2'd0;
   localparam logic [CAT_IDX_W-1:0] CAT_LAST     = 2'd3;

   // ceil(32768 * sin(k - 0.5 deg)) for k = 1..90
   localparam logic [15:0] HALF_DEG_SINE [NUM_LEAN_STEPS] = '{
      16'd286,   16'd858,   16'd1430,  16'd2001,  16'd2571,
      16'd3141,  16'd3710,  16'd4278,  16'd4844,  16'd5409,
      16'd5972,  16'd6533,  16'd7093,  16'd7650,  16'd8205,
      16'd8757,  16'd9307,  16'd9854,  16'd10398, 16'd10939,
      16'd11476, 16'd12010, 16'd12540, 16'd13067, 16'd13589,
      16'd14107, 16'd14622, 16'd15131, 16'd15636, 16'd16136,
      16'd16632, 16'd17122, 16'd17607, 16'd18086, 16'd18560,
      16'd19029, 16'd19492, 16'd19948, 16'd20399, 16'd20844,
      16'd21282, 16'd21713, 16'd22138, 16'd22557, 16'd22968,
      16'd23372, 16'd23770, 16'd24160, 16'd24542, 16'd24917,
      16'd25285, 16'd25645, 16'd25997, 16'd26341, 16'd26677,
      16'd27005, 16'd27325, 16'd27637, 16'd27940, 16'd28234,
      16'd28520, 16'd28798, 16'd29066, 16'd29326, 16'd29576,
      16'd29818, 16'd30051, 16'd30274, 16'd30488, 16'd30693,
      16'd30889, 16'd31075, 16'd31252, 16'd31419, 16'd31577,
      16'd31725, 16'd31863, 16'd31992, 16'd32111, 16'd32220,
      16'd32319, 16'd32409, 16'd32488, 16'd32558, 16'd32618,
      16'd32667, 16'd32707, 16'd32737, 16'd32757, 16'd32767
   };

   typedef struct packed {
      logic [THICK_W-1:0]         thin_critical_limit;
      logic [THICK_W-1:0]         thin_warning_limit;
      logic signed [HEIGHT_W-1:0] bed_band_top;
   } cfg_type;

   typedef struct packed {
      logic                       thickness_valid;
      logic [THICK_W-1:0]         wall_thickness;
      logic [AREA_W-1:0]          facet_area;
      logic signed [NORMAL_W-1:0] normal_up;
      logic signed [HEIGHT_W-1:0] top_height;
      logic                       final_facet;
   } facet_type;

   typedef struct packed {
      logic               nonzero;
      logic [FLAGS_W-1:0] flags;
      logic [DEG_W-1:0]   degrees;
      logic [LEAN_W-1:0]  lean;
      logic [AREA_W-1:0]  area;
      logic               final_facet;
   } class_type;

   typedef struct packed {
      logic update;
      logic clear;
   } acc_ctl_type;

   typedef struct packed {
      logic [CAT_FACETS_W-1:0] facets;
      logic [CAT_AREA_W-1:0]   area;
      logic [LEAN_W-1:0]       max_lean;
      logic [CAT_AREA_W-1:0]   mesh_area;
   } cat_type;

endpackage

`default_nettype wire

// File: hdl/fpc_csr.sv
// APB-style register file holding the thickness limits and bed band top.
// Depends on fpc_pkg.
`default_nettype none

module fpc_csr
   import fpc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready,
   output cfg_type                    cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   csr_index_type reg_idx;
   logic          write_hit;

   assign reg_idx    = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign write_hit  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_hit) begin
         unique case (reg_idx)
            CSR_THIN_CRITICAL: cfg_in.thin_critical_limit = csr_pwdata[THICK_W-1:0];
            CSR_THIN_WARNING:  cfg_in.thin_warning_limit  = csr_pwdata[THICK_W-1:0];
            CSR_BED_BAND_TOP:  cfg_in.bed_band_top = $signed(csr_pwdata[HEIGHT_W-1:0]);
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         CSR_THIN_CRITICAL: csr_prdata = CSR_DATA_W'(cfg_ff.thin_critical_limit);
         CSR_THIN_WARNING:  csr_prdata = CSR_DATA_W'(cfg_ff.thin_warning_limit);
         CSR_BED_BAND_TOP:  csr_prdata = CSR_DATA_W'($unsigned(cfg_ff.bed_band_top));
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/fpc_classify.sv
// Per-facet classification: thin flags, lean angle from the sine table, overhang.
// Combinational; depends on fpc_pkg.
`default_nettype none

module fpc_classify
   import fpc_pkg::*;
(
   input  wire facet_type item,
   input  wire cfg_type   cfg,
   output class_type      result
);

   logic [NORMAL_W:0]         nz_ext;
   logic [NORMAL_W:0]         mag;
   logic [NUM_LEAN_STEPS:0]   therm;
   logic [NUM_LEAN_STEPS-1:0] step_edge;
   logic [LEAN_W-1:0]         lean;
   logic                      downward;
   logic                      thin_crit;
   logic                      thin_warn;
   logic                      over_ext;
   logic                      over_int;
   logic                      nonzero;

   assign nz_ext   = {item.normal_up[NORMAL_W-1], item.normal_up};
   assign downward = item.normal_up[NORMAL_W-1];
   assign mag      = downward ? (~nz_ext + 1'b1) : nz_ext;

   // The table rises, so the compares form a thermometer; encode its top edge.
   always_comb begin
      therm[NUM_LEAN_STEPS] = 1'b0;
      for (int k = 0; k < NUM_LEAN_STEPS; k++) begin
         therm[k] = (mag >= {1'b0, HALF_DEG_SINE[k]});
      end
      for (int k = 0; k < NUM_LEAN_STEPS; k++) begin
         step_edge[k] = therm[k] && !therm[k+1];
      end
      lean = '0;
      for (int k = 0; k < NUM_LEAN_STEPS; k++) begin
         lean = lean | (step_edge[k] ? LEAN_W'(k + 1) : '0);
      end
   end

   assign nonzero   = (item.facet_area != '0);
   assign thin_crit = item.thickness_valid &&
                      (item.wall_thickness < cfg.thin_critical_limit);
   assign thin_warn = item.thickness_valid && !thin_crit &&
                      (item.wall_thickness < cfg.thin_warning_limit);
   assign over_ext  = (lean != '0) && downward &&
                      ($signed(item.top_height) > $signed(cfg.bed_band_top));
   assign over_int  = (lean != '0) && !downward;

   always_comb begin
      result             = '0;
      result.nonzero     = nonzero;
      result.lean        = lean;
      result.area        = item.facet_area;
      result.final_facet = item.final_facet;
      result.degrees     = NOT_OVERHANG;
      if (nonzero) begin
         result.flags[FLAG_THIN_CRITICAL] = thin_crit;
         result.flags[FLAG_THIN_WARNING]  = thin_warn;
         result.flags[FLAG_EXTERNAL]      = over_ext;
         result.flags[FLAG_INTERNAL]      = over_int;
         if (over_ext || over_int) begin
            result.degrees = DEG_W'(lean);
         end
      end
   end

endmodule

`default_nettype wire

// File: hdl/fpc_accum.sv
// Per-flag statistics stores: saturating counts and area sums, largest lean,
// mesh area total, with category readout and clear. Depends on fpc_pkg.
`default_nettype none

module fpc_accum
   import fpc_pkg::*;
#(
   parameter int COUNT_BITS = 24,
   parameter int SUM_BITS   = 48
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire acc_ctl_type          ctl,
   input  wire class_type            item,
   input  wire logic [CAT_IDX_W-1:0] cat_idx,
   output cat_type                   cat
);

   logic [COUNT_BITS-1:0] count_ff [NUM_FLAGS];
   logic [COUNT_BITS-1:0] count_in [NUM_FLAGS];
   logic [SUM_BITS-1:0]   sum_ff   [NUM_FLAGS];
   logic [SUM_BITS-1:0]   sum_in   [NUM_FLAGS];
   logic [LEAN_W-1:0]     lean_ff  [NUM_FLAGS];
   logic [LEAN_W-1:0]     lean_in  [NUM_FLAGS];
   logic [SUM_BITS-1:0]   total_ff;
   logic [SUM_BITS-1:0]   total_in;
   logic [SUM_BITS:0]     sum_wide [NUM_FLAGS];
   logic [SUM_BITS:0]     total_wide;

   always_comb begin
      total_wide = {1'b0, total_ff} + (SUM_BITS + 1)'(item.area);
      total_in   = total_ff;
      if (ctl.clear) begin
         total_in = '0;
      end else if (ctl.update) begin
         total_in = total_wide[SUM_BITS] ? '1 : total_wide[SUM_BITS-1:0];
      end
      for (int k = 0; k < NUM_FLAGS; k++) begin
         sum_wide[k] = {1'b0, sum_ff[k]} + (SUM_BITS + 1)'(item.area);
         count_in[k] = count_ff[k];
         sum_in[k]   = sum_ff[k];
         lean_in[k]  = lean_ff[k];
         if (ctl.clear) begin
            count_in[k] = '0;
            sum_in[k]   = '0;
            lean_in[k]  = '0;
         end else if (ctl.update && item.flags[k]) begin
            if (count_ff[k] != '1) begin
               count_in[k] = count_ff[k] + 1'b1;
            end
            sum_in[k] = sum_wide[k][SUM_BITS] ? '1 : sum_wide[k][SUM_BITS-1:0];
            // Only the overhang categories track lean.
            if ((k >= FLAG_EXTERNAL) && (item.lean > lean_ff[k])) begin
               lean_in[k] = item.lean;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         for (int k = 0; k < NUM_FLAGS; k++) begin
            count_ff[k] <= '0;
            sum_ff[k]   <= '0;
            lean_ff[k]  <= '0;
         end
      end else begin
         total_ff <= total_in;
         for (int k = 0; k < NUM_FLAGS; k++) begin
            count_ff[k] <= count_in[k];
            sum_ff[k]   <= sum_in[k];
            lean_ff[k]  <= lean_in[k];
         end
      end
   end

   assign cat.facets    = CAT_FACETS_W'(count_ff[cat_idx]);
   assign cat.area      = CAT_AREA_W'(sum_ff[cat_idx]);
   assign cat.max_lean  = lean_ff[cat_idx];
   assign cat.mesh_area = CAT_AREA_W'(total_ff);

endmodule

`default_nettype wire

// File: hdl/facet_printability_classifier_core.sv
// Facet printability classifier, top level.
// Throughput: one facet per cycle through input, classify and result registers
// while the result side accepts beats; a final facet adds four category beats,
// during which the request side stalls.
// Reset (synchronous, active high) clears pipeline valids, the statistics
// stores and the configuration registers.
`default_nettype none
`include "facet_printability_classifier_core_assert.svh"

module facet_printability_classifier_core
   import fpc_pkg::*;
#(
   parameter int COUNT_BITS = 24,
   parameter int SUM_BITS   = 48
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request channel
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // tdata: wall_thickness[19:0], facet_area[41:20], normal_up[57:42],
   //        top_height[78:58], zero pad[79]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // tuser: thickness_valid
   input  wire logic                  req_tuser,
   input  wire logic                  req_tlast,
   // result channel
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // tdata: flag_bits[3:0], overhang_degrees[11:4], category_index[13:12],
   //        category_facets[37:14], category_area[85:38],
   //        category_max_lean[92:86], mesh_area[140:93], zero pad[143:141]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // tuser: result_kind
   output logic                       rsp_tuser,
   output logic                       rsp_tlast,
   // configuration port
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   cfg_type                cfg;

   // input register
   logic                   s1_valid_ff;
   logic                   s1_valid_in;
   facet_type              s1_item_ff;
   facet_type              s1_item_in;

   // classification register
   class_type              class_now;
   logic                   s2_valid_ff;
   logic                   s2_valid_in;
   class_type              s2_class_ff;
   class_type              s2_class_in;

   // category drain after a final facet
   logic                   drain_ff;
   logic                   drain_in;
   logic [CAT_IDX_W-1:0]   cat_idx_ff;
   logic [CAT_IDX_W-1:0]   cat_idx_in;
   cat_type                cat;
   acc_ctl_type            acc_ctl;

   // result register
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic                   rsp_kind_ff;
   logic                   rsp_kind_in;
   logic                   rsp_last_ff;
   logic                   rsp_last_in;
   logic [RSP_DATA_W-1:0]  rsp_data_ff;
   logic [RSP_DATA_W-1:0]  rsp_data_in;

   logic                   out_open;
   logic                   commit;
   logic                   cat_load;
   logic                   s2_open;
   logic                   s1_open;

   fpc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake chain: the result register opens when empty or being drained;
   // the classified facet commits only when no category beats are pending.
   assign out_open   = !rsp_valid_ff || rsp_tready;
   assign commit     = s2_valid_ff && !drain_ff && out_open;
   assign cat_load   = drain_ff && out_open;
   assign s2_open    = !s2_valid_ff || commit;
   assign s1_open    = !s1_valid_ff || s2_open;
   assign req_tready = s1_open;

   // Stage 1: capture the request beat.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_item_in  = s1_item_ff;
      if (s1_open) begin
         s1_valid_in                = req_tvalid;
         s1_item_in.thickness_valid = req_tuser;
         s1_item_in.wall_thickness  = req_tdata[REQ_THICK_LSB +: THICK_W];
         s1_item_in.facet_area      = req_tdata[REQ_AREA_LSB +: AREA_W];
         s1_item_in.normal_up       = $signed(req_tdata[REQ_NORMAL_LSB +: NORMAL_W]);
         s1_item_in.top_height      = $signed(req_tdata[REQ_TOP_LSB +: HEIGHT_W]);
         s1_item_in.final_facet     = req_tlast;
      end
   end

   // Stage 2: classify the held facet.
   fpc_classify u_classify (
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (class_now)
   );

   always_comb begin
      s2_valid_in = s2_valid_ff;
      s2_class_in = s2_class_ff;
      if (s2_open) begin
         s2_valid_in = s1_valid_ff;
         s2_class_in = class_now;
      end
   end

   // Stage 3: fold the facet into the stores, or read one category out.
   assign acc_ctl.update = commit && s2_class_ff.nonzero;
   assign acc_ctl.clear  = cat_load && (cat_idx_ff == CAT_LAST);

   fpc_accum #(
      .COUNT_BITS (COUNT_BITS),
      .SUM_BITS   (SUM_BITS)
   ) u_accum (
      .clock   (clock),
      .reset   (reset),
      .ctl     (acc_ctl),
      .item    (s2_class_ff),
      .cat_idx (cat_idx_ff),
      .cat     (cat)
   );

   // Start the drain after a final facet; advance one category per open slot,
   // and drop out of the drain once the last category is loaded.
   always_comb begin
      drain_in   = drain_ff;
      cat_idx_in = cat_idx_ff;
      if (commit && s2_class_ff.final_facet) begin
         drain_in   = 1'b1;
         cat_idx_in = CAT_FIRST;
      end else if (cat_load) begin
         cat_idx_in = cat_idx_ff + 1'b1;
         if (cat_idx_ff == CAT_LAST) begin
            drain_in = 1'b0;
         end
      end
   end

   // Result register: facet beat on commit, category beat while draining.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_open) begin
         rsp_valid_in = commit || cat_load;
         rsp_data_in  = '0;
         if (cat_load) begin
            rsp_kind_in = KIND_CATEGORY;
            rsp_last_in = (cat_idx_ff == CAT_LAST);
            rsp_data_in[RSP_CAT_IDX_LSB +: CAT_IDX_W]       = cat_idx_ff;
            rsp_data_in[RSP_CAT_FACETS_LSB +: CAT_FACETS_W] = cat.facets;
            rsp_data_in[RSP_CAT_AREA_LSB +: CAT_AREA_W]     = cat.area;
            rsp_data_in[RSP_CAT_LEAN_LSB +: LEAN_W]         = cat.max_lean;
            rsp_data_in[RSP_MESH_AREA_LSB +: CAT_AREA_W]    = cat.mesh_area;
         end else begin
            rsp_kind_in = KIND_FACET;
            rsp_last_in = 1'b0;
            rsp_data_in[RSP_FLAGS_LSB +: FLAGS_W] = s2_class_ff.flags;
            rsp_data_in[RSP_DEG_LSB +: DEG_W]     = s2_class_ff.degrees;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         drain_ff     <= 1'b0;
         cat_idx_ff   <= CAT_FIRST;
         rsp_valid_ff <= 1'b0;
         rsp_kind_ff  <= KIND_FACET;
         rsp_last_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         drain_ff     <= drain_in;
         cat_idx_ff   <= cat_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_kind_ff  <= rsp_kind_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   // Payload registers hold without reset.
   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      s2_class_ff <= s2_class_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

   // A final facet that commits opens a drain at the first category.
   `FPC_ASSERT_NEXT(a_final_opens_drain, clock, reset, commit && s2_class_ff.final_facet, drain_ff && (cat_idx_ff == CAT_FIRST))
   // Loading the last category closes the drain.
   `FPC_ASSERT_NEXT(a_last_cat_closes_drain, clock, reset, cat_load && (cat_idx_ff == CAT_LAST), !drain_ff)
   // The run end mark only rides on a category beat.
   `FPC_ASSERT_NOW(a_last_is_category, clock, reset, rsp_valid_ff && rsp_last_ff, rsp_kind_ff == KIND_CATEGORY)
   // A facet beat without overhang flags reports no overhang degree.
   `FPC_ASSERT_NOW(a_flat_degrees, clock, reset, rsp_valid_ff && (rsp_kind_ff == KIND_FACET) && !rsp_data_ff[RSP_FLAGS_LSB + FLAG_EXTERNAL] && !rsp_data_ff[RSP_FLAGS_LSB + FLAG_INTERNAL], rsp_data_ff[RSP_DEG_LSB +: DEG_W] == NOT_OVERHANG)

endmodule

`default_nettype wire
